// File: rtl/ael_pkg.sv
// Shared types, character codes and token helpers for the expression lexer.
`default_nettype none

package ael_pkg;

    localparam int KIND_W  = 4;
    localparam int MANT_W  = 61;
    localparam int FRAC_W  = 5;
    localparam int POS_W   = 16;
    localparam int TDATA_W = 88;
    localparam int PAD_W   = TDATA_W - MANT_W - FRAC_W - POS_W;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_NUM   = 4'd0,
        KIND_PLUS  = 4'd1,
        KIND_MINUS = 4'd2,
        KIND_MULT  = 4'd3,
        KIND_DIV   = 4'd4,
        KIND_OPEN  = 4'd5,
        KIND_CLOSE = 4'd6,
        KIND_ERR   = 4'd7,
        KIND_END   = 4'd8,
        KIND_NONE  = 4'd15
    } kind_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MULT  = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        kind_t                    kind;
        logic signed [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0]        frac_digits;
        logic [POS_W-1:0]         position;
        logic                     last_token;
    } token_t;

    // One queue entry: the tokens produced by one character (one or two).
    typedef struct packed {
        logic   second;
        token_t tok0;
        token_t tok1;
    } pair_t;

    function automatic token_t make_tok(input kind_t k,
                                        input logic signed [MANT_W-1:0] m,
                                        input logic [FRAC_W-1:0] f,
                                        input logic [POS_W-1:0] p);
        token_t t;
        t.kind        = k;
        t.mantissa    = m;
        t.frac_digits = f;
        t.position    = p;
        t.last_token  = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ael_front.sv
// Front end: classifies each character, tracks number state, builds tokens.
`default_nettype none

module ael_front
    import ael_pkg::*;
#(
    parameter int MAX_DIGITS = 18,
    parameter int INDEX_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] char_code,
    input  wire logic       is_last,
    output logic            push,
    output pair_t           entry
);

    logic                     num_active_reg,   num_active_next;
    logic signed [MANT_W-1:0] mant_reg,         mant_next;
    logic                     num_negative_reg, num_negative_next;
    logic                     seen_point_reg,   seen_point_next;
    logic [FRAC_W-1:0]        frac_count_reg,   frac_count_next;
    logic [FRAC_W-1:0]        digit_count_reg,  digit_count_next;
    logic                     minus_pending_reg, minus_pending_next;
    kind_t                    prev_kind_reg,    prev_kind_next;
    logic [INDEX_BITS-1:0]    char_index_reg,   char_index_next;
    logic                     dropping_reg,     dropping_next;

    logic                     is_digit, is_ws;
    logic [3:0]               digit;
    logic signed [MANT_W-1:0] digit_s, mant_acc;
    logic [POS_W-1:0]         pos;
    kind_t                    prev_eff;
    token_t                   tok_a, tok_b, tok_c, t0, t1;
    logic                     va, vb, vc, v0, v1;

    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_ws    = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
    assign digit    = 4'(char_code - CH_ZERO);
    assign pos      = POS_W'(char_index_reg);

    // Mantissa is kept signed, so a negative number accumulates by subtracting.
    assign digit_s  = num_negative_reg ? -MANT_W'(digit) : MANT_W'(digit);
    assign mant_acc = (mant_reg <<< 3) + (mant_reg <<< 1) + digit_s;

    // Flushed pending item (minus or number) decides the minus context.
    assign prev_eff = minus_pending_reg ? KIND_MINUS :
                      num_active_reg    ? KIND_NUM   : prev_kind_reg;

    always_comb
    begin
        num_active_next    = num_active_reg;
        mant_next          = mant_reg;
        num_negative_next  = num_negative_reg;
        seen_point_next    = seen_point_reg;
        frac_count_next    = frac_count_reg;
        digit_count_next   = digit_count_reg;
        minus_pending_next = minus_pending_reg;
        prev_kind_next     = prev_kind_reg;
        dropping_next      = dropping_reg;
        char_index_next    = (char_index_reg != '1) ? char_index_reg + 1'b1 : char_index_reg;

        va    = 1'b0;
        vb    = 1'b0;
        tok_a = make_tok(KIND_NUM, mant_reg, frac_count_reg, '0);
        tok_b = make_tok(KIND_ERR, '0, '0, pos);

        if (!dropping_reg)
        begin
            if (is_digit)
            begin
                if (minus_pending_reg || !num_active_reg)
                begin
                    minus_pending_next = 1'b0;
                    num_active_next    = 1'b1;
                    num_negative_next  = minus_pending_reg;
                    mant_next          = minus_pending_reg ? -MANT_W'(digit) : MANT_W'(digit);
                    seen_point_next    = 1'b0;
                    frac_count_next    = '0;
                    digit_count_next   = FRAC_W'(1);
                end
                else if (digit_count_reg >= FRAC_W'(MAX_DIGITS))
                begin
                    vb = 1'b1;
                end
                else
                begin
                    mant_next        = mant_acc;
                    digit_count_next = digit_count_reg + 1'b1;
                    if (seen_point_reg)
                    begin
                        frac_count_next = frac_count_reg + 1'b1;
                    end
                end
            end
            else if ((char_code == CH_POINT) && num_active_reg)
            begin
                if (seen_point_reg)
                begin
                    vb = 1'b1;
                end
                else
                begin
                    seen_point_next = 1'b1;
                end
            end
            else
            begin
                // Flush whatever is pending, then handle the character.
                va = minus_pending_reg || num_active_reg;
                if (minus_pending_reg)
                begin
                    tok_a = make_tok(KIND_MINUS, '0, '0, '0);
                end
                minus_pending_next = 1'b0;
                num_active_next    = 1'b0;
                vb                 = !is_ws;
                case (char_code)
                    CH_PLUS:  tok_b = make_tok(KIND_PLUS,  '0, '0, '0);
                    CH_MULT:  tok_b = make_tok(KIND_MULT,  '0, '0, '0);
                    CH_DIV:   tok_b = make_tok(KIND_DIV,   '0, '0, '0);
                    CH_OPEN:  tok_b = make_tok(KIND_OPEN,  '0, '0, '0);
                    CH_CLOSE: tok_b = make_tok(KIND_CLOSE, '0, '0, '0);
                    CH_MINUS:
                    begin
                        tok_b = make_tok(KIND_MINUS, '0, '0, '0);
                        if ((prev_eff == KIND_NONE) || (prev_eff == KIND_PLUS) ||
                            (prev_eff == KIND_MULT) || (prev_eff == KIND_DIV))
                        begin
                            vb                 = 1'b0;
                            minus_pending_next = 1'b1;
                        end
                    end
                    default:  tok_b = make_tok(KIND_ERR, '0, '0, pos);
                endcase
            end

            if (vb && (tok_b.kind == KIND_ERR))
            begin
                num_active_next    = 1'b0;
                minus_pending_next = 1'b0;
                dropping_next      = 1'b1;
            end
        end

        // End-of-expression flush of what is still pending after this character.
        vc = is_last && !dropping_reg && (minus_pending_next || num_active_next);
        if (minus_pending_next)
        begin
            tok_c = make_tok(KIND_MINUS, '0, '0, '0);
        end
        else
        begin
            tok_c = make_tok(KIND_NUM, mant_next, frac_count_next, '0);
        end

        if (va)
        begin
            t0 = tok_a;
            t1 = vb ? tok_b : tok_c;
            v0 = 1'b1;
            v1 = vb || vc;
        end
        else if (vb)
        begin
            t0 = tok_b;
            t1 = tok_c;
            v0 = 1'b1;
            v1 = vc;
        end
        else
        begin
            t0 = tok_c;
            t1 = tok_c;
            v0 = vc;
            v1 = 1'b0;
        end

        if (is_last && !v0)
        begin
            t0 = make_tok(KIND_END, '0, '0, '0);
            v0 = 1'b1;
        end

        if (v1)
        begin
            prev_kind_next = t1.kind;
        end
        else if (v0)
        begin
            prev_kind_next = t0.kind;
        end

        if (is_last)
        begin
            if (v1)
            begin
                t1.last_token = 1'b1;
            end
            else
            begin
                t0.last_token = 1'b1;
            end
            num_active_next    = 1'b0;
            mant_next          = '0;
            num_negative_next  = 1'b0;
            seen_point_next    = 1'b0;
            frac_count_next    = '0;
            digit_count_next   = '0;
            minus_pending_next = 1'b0;
            prev_kind_next     = KIND_NONE;
            char_index_next    = '0;
            dropping_next      = 1'b0;
        end
    end

    assign push         = accept && v0;
    assign entry.second = v1;
    assign entry.tok0   = t0;
    assign entry.tok1   = t1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_active_reg    <= 1'b0;
            mant_reg          <= '0;
            num_negative_reg  <= 1'b0;
            seen_point_reg    <= 1'b0;
            frac_count_reg    <= '0;
            digit_count_reg   <= '0;
            minus_pending_reg <= 1'b0;
            prev_kind_reg     <= KIND_NONE;
            char_index_reg    <= '0;
            dropping_reg      <= 1'b0;
        end
        else if (accept)
        begin
            num_active_reg    <= num_active_next;
            mant_reg          <= mant_next;
            num_negative_reg  <= num_negative_next;
            seen_point_reg    <= seen_point_next;
            frac_count_reg    <= frac_count_next;
            digit_count_reg   <= digit_count_next;
            minus_pending_reg <= minus_pending_next;
            prev_kind_reg     <= prev_kind_next;
            char_index_reg    <= char_index_next;
            dropping_reg      <= dropping_next;
        end
    end

    // A number and a held minus never coexist; an error clears both.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(num_active_reg && minus_pending_reg) &&
        !(dropping_reg && (num_active_reg || minus_pending_reg)))
        else $error("front: inconsistent number state");

    assert property (@(posedge clk) disable iff (!rst_n)
        num_active_reg |-> (digit_count_reg != '0) &&
                           (digit_count_reg <= FRAC_W'(MAX_DIGITS)))
        else $error("front: digit count out of range");

endmodule

`default_nettype wire

// File: rtl/ael_queue.sv
// Short register queue of token pairs between front and back end.
`default_nettype none

module ael_queue
    import ael_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire pair_t wr_entry,
    input  wire logic  pop,
    output pair_t      rd_entry,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pair_t              slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wr_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && empty))
        else $error("queue: overflow or underflow");

endmodule

`default_nettype wire

// File: rtl/ael_back.sv
// Back end: sends the one or two tokens of each queue entry onto the output stream.
`default_nettype none

module ael_back
    import ael_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire pair_t head,
    input  wire logic  empty,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output token_t     out_tok
);

    logic phase_reg, phase_next;
    logic done;

    assign out_valid = !empty;
    assign out_tok   = phase_reg ? head.tok1 : head.tok0;
    assign done      = phase_reg || !head.second;
    assign pop       = out_valid && out_ready && done;

    always_comb
    begin
        phase_next = phase_reg;
        if (out_valid && out_ready)
        begin
            phase_next = !done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Second-token phase only exists for a held two-token entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> out_valid && head.second)
        else $error("back: second phase without a two-token entry");

endmodule

`default_nettype wire

// File: rtl/arithmetic_expression_lexer_unit.sv
// Top level of the arithmetic expression lexer: character stream in, token stream out.
`default_nettype none

// Arithmetic expression lexer. One character item enters per clock on the slave
// stream while the queue is not full (s_tdata = character code, s_tlast = last
// character of the expression); tokens leave on the master stream, one per clock
// while m_tready is high. Each character is classified and folded into the number
// state in the cycle it is accepted (a times-ten accumulate), and yields zero, one
// or two tokens, which are written into the queue. A four-entry queue of token
// pairs separates the two sides, so characters keep flowing while the output
// stalls; the input takes one character per cycle as long as the output drains,
// and a character that yields two tokens sends them out one after the other.
// Numbers carry a signed decimal mantissa and a count of fraction digits; a minus
// right after start, plus, multiply or divide and followed by a digit becomes the
// number's sign. After an error token every character up to the last one is
// dropped, and the last one then gives an end token. The final token of each
// expression has m_tlast set. No clearing pass: the block is ready right after reset.
module arithmetic_expression_lexer_unit
    import ael_pkg::*;
#(
    parameter int MAX_DIGITS = 18,
    parameter int INDEX_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] char_code
    input  wire logic               s_tlast,   // is_last
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [60:0] mantissa, [65:61] frac_digits,
                                               // [81:66] position, [87:82] zero
    output logic [KIND_W-1:0]       m_tuser,   // [3:0] kind
    output logic                    m_tlast    // last_token
);

    logic   accept;
    logic   push, pop, full, empty;
    pair_t  entry, head;
    token_t out_tok;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    ael_front #(
        .MAX_DIGITS (MAX_DIGITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (s_tdata),
        .is_last   (s_tlast),
        .push      (push),
        .entry     (entry)
    );

    ael_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (entry),
        .pop      (pop),
        .rd_entry (head),
        .full     (full),
        .empty    (empty)
    );

    ael_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    // Pack the token; kind travels as tuser, the final-token flag as tlast.
    assign m_tdata = {{PAD_W{1'b0}}, out_tok.position, out_tok.frac_digits,
                      out_tok.mantissa};
    assign m_tuser = out_tok.kind;
    assign m_tlast = out_tok.last_token;

    // An end token always closes its expression.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_END)) |-> m_tlast)
        else $error("top: end token without tlast");

endmodule

`default_nettype wire
